### rtl/ccs_pkg.sv
package ccs_pkg;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// Output queue: two result slots per byte plus two for drain slack.
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic [7:0] {
		MODE_PLAIN    = 8'b0000_0001,
		MODE_STRING   = 8'b0000_0010,
		MODE_SLASH    = 8'b0000_0100,
		MODE_LINE     = 8'b0000_1000,
		MODE_BLOCK    = 8'b0001_0000,
		MODE_CHAR     = 8'b0010_0000,
		MODE_STR_ESC  = 8'b0100_0000,
		MODE_LINE_ESC = 8'b1000_0000
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t mode;
		logic       prev_was_star;
	} scan_state_t;

	// Up to two kept bytes per input byte; the last one carries run_last.
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} scan_res_t;

	typedef struct packed {
		logic [7:0] kept;
		logic       last;
	} outq_entry_t;

endpackage

### rtl/ccs_scan.sv
module ccs_scan (
	input  ccs_pkg::scan_state_t state,
	input  logic [7:0]           text,
	output ccs_pkg::scan_state_t state_next,
	output ccs_pkg::scan_res_t   res
);
	import ccs_pkg::*;

	// Mode after a byte handled as plain text.
	scan_mode_t plain_mode;

	always_comb begin
		if (text == CH_DQUOTE) begin
			plain_mode = MODE_STRING;
		end else if (text == CH_SQUOTE) begin
			plain_mode = MODE_CHAR;
		end else begin
			plain_mode = MODE_PLAIN;
		end
	end

	always_comb begin
		state_next = state;
		res.count  = 2'd0;
		res.byte0  = text;
		res.byte1  = text;
		unique case (state.mode)
			MODE_STRING: begin
				res.count = 2'd1;
				if (text == CH_DQUOTE || text == CH_NL) begin
					state_next.mode = MODE_PLAIN;
				end else if (text == CH_BSLASH) begin
					state_next.mode = MODE_STR_ESC;
				end
			end
			MODE_STR_ESC: begin
				res.count       = 2'd1;
				state_next.mode = MODE_STRING;
			end
			MODE_CHAR: begin
				res.count = 2'd1;
				if (text == CH_SQUOTE || text == CH_NL) begin
					state_next.mode = MODE_PLAIN;
				end
			end
			MODE_SLASH: begin
				if (text == CH_SLASH) begin
					state_next.mode = MODE_LINE;
				end else if (text == CH_STAR) begin
					state_next.mode          = MODE_BLOCK;
					state_next.prev_was_star = 1'b0;
				end else begin
					// Release the held slash, then the byte as plain text.
					res.count       = 2'd2;
					res.byte0       = CH_SLASH;
					state_next.mode = plain_mode;
				end
			end
			MODE_LINE: begin
				if (text == CH_BSLASH) begin
					state_next.mode = MODE_LINE_ESC;
				end else if (text == CH_NL) begin
					res.count       = 2'd1;
					state_next.mode = MODE_PLAIN;
				end
			end
			MODE_LINE_ESC: begin
				state_next.mode = MODE_LINE;
			end
			MODE_BLOCK: begin
				if (state.prev_was_star && text == CH_SLASH) begin
					state_next.mode = MODE_PLAIN;
				end else begin
					state_next.prev_was_star = (text == CH_STAR);
				end
			end
			MODE_PLAIN: begin
				if (text == CH_SLASH) begin
					state_next.mode = MODE_SLASH;
				end else begin
					res.count       = 2'd1;
					state_next.mode = plain_mode;
				end
			end
			default: begin
				state_next.mode = MODE_PLAIN;
			end
		endcase
	end

endmodule

### rtl/c_comment_stripper.sv
// A source byte is registered in the input stage, then in a 4-entry result queue.
// Throughput: one source byte per cycle while the queue holds at most two results;
//   a slash release gives two results; one drains per cycle with kept_ready high.
// Reset (arst_n low, asynchronous): plain-text mode, no block-comment star seen,
//   input stage and result queue empty.
// A slash still held when the stream stops is never emitted.
module c_comment_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] text_byte,
	output logic       kept_valid,
	input  logic       kept_ready,
	output logic [7:0] kept_byte,
	output logic       run_last
);
	import ccs_pkg::*;

	// Input stage: one registered source byte.
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance_s1;

	// Scanner state.
	scan_state_t       state_q;
	scan_state_t       state_next;
	scan_res_t         res;

	// Result queue.
	outq_entry_t       outq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wr_ptr_q;
	logic [OUTQ_AW-1:0] rd_ptr_q;
	logic [OUTQ_CW-1:0] count_q;
	logic              pop;
	logic [1:0]        push_n;
	logic [OUTQ_AW-1:0] wr_ptr_p1;

	ccs_scan u_scan (
		.state      (state_q),
		.text       (byte_s1),
		.state_next (state_next),
		.res        (res)
	);

	// Advance the input stage only when the queue can absorb a worst-case pair,
	// so a stalled output never loses a result.
	assign advance_s1 = valid_s1 && (count_q <= OUTQ_CW'(OUTQ_DEPTH - 2));
	assign text_ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1 <= text_byte;
		end
	end

	// Commit the scanner state once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_PLAIN, prev_was_star: 1'b0};
		end else if (advance_s1) begin
			state_q <= state_next;
		end
	end

	assign push_n    = advance_s1 ? res.count : 2'd0;
	assign pop       = kept_valid && kept_ready;
	assign wr_ptr_p1 = wr_ptr_q + OUTQ_AW'(1);

	// Write one or two results; run_last marks the final one of the byte.
	always_ff @(posedge clk) begin
		if (push_n == 2'd1) begin
			outq_q[wr_ptr_q] <= '{kept: res.byte1, last: 1'b1};
		end else if (push_n == 2'd2) begin
			outq_q[wr_ptr_q]  <= '{kept: res.byte0, last: 1'b0};
			outq_q[wr_ptr_p1] <= '{kept: res.byte1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
			end
			count_q <= count_q + OUTQ_CW'(push_n) - OUTQ_CW'(pop);
		end
	end

	// Present the queue head; each entry is a registered result.
	assign kept_valid = (count_q != '0);
	assign kept_byte  = outq_q[rd_ptr_q].kept;
	assign run_last   = outq_q[rd_ptr_q].last;

	// Queue occupancy stays within its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUTQ_CW'(OUTQ_DEPTH))
		else $error("result queue overflow");

	// Occupancy tracks the pointers.
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == OUTQ_CW'(OUTQ_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");

	// A byte that leaves the input stage never pushes onto a queue without room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |-> (count_q + OUTQ_CW'(res.count) <= OUTQ_CW'(OUTQ_DEPTH)))
		else $error("push without room");

	// A held byte that cannot advance stays in the input stage.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input stage lost a byte");

endmodule

### bench/tb_c_comment_stripper.sv
module tb_c_comment_stripper;
	timeunit 1ns;
	timeprecision 1ps;

	import ccs_pkg::*;

	// Bound the run well above the slowest legal pace: every byte waiting out the longest
	// source gap, and two results each waiting out the longest sink stall.
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_BYTES = 2000;
	// Settle time after the last expected result. It leaves room for a stray result,
	// such as a dropped trailing slash showing up late.
	localparam int TAIL_CYCLES  = 12;

	// One kept byte as the output port should present it
	typedef struct packed {
		logic [7:0] kept;
		logic       last;
	} kept_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_ready;
	logic [7:0] text_byte  = 8'h00;
	logic       kept_valid;
	logic       kept_ready = 1'b0;
	logic [7:0] kept_byte;
	logic       run_last;

	c_comment_stripper u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.kept_valid (kept_valid),
		.kept_ready (kept_ready),
		.kept_byte  (kept_byte),
		.run_last   (run_last)
	);

	always #4 clk = ~clk;

	// Source bytes not yet driven, and kept bytes predicted but not yet seen
	logic [7:0] source_q[$];
	kept_t      kept_exp_q[$];

	// Stripper state as predicted from the accepted bytes
	scan_mode_t lex_mode  = MODE_PLAIN;
	logic       star_seen = 1'b0;
	logic [7:0] step_kept[$];

	int cycles         = 0;
	int err_count      = 0;
	int bytes_sent     = 0;
	int results_seen   = 0;
	int double_results = 0;
	int comments_seen  = 0;

	// Gap-free stretches on each side, redrawn at random by the cycle-count block
	logic quiet_in  = 1'b0;
	logic quiet_out = 1'b0;

	int   src_gap  = 0;
	int   snk_stall = 0;
	logic src_hold;
	logic timed_out;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Plain-text byte: quotes open a literal, a slash is held back, the rest passes.
	task automatic plain_char(input logic [7:0] c);
		if (c == CH_DQUOTE) begin
			step_kept.push_back(c);
			lex_mode = MODE_STRING;
		end else if (c == CH_SQUOTE) begin
			step_kept.push_back(c);
			lex_mode = MODE_CHAR;
		end else if (c == CH_SLASH) begin
			lex_mode = MODE_SLASH;
		end else begin
			step_kept.push_back(c);
		end
	endtask

	// Advance the predicted state by one accepted byte and queue the kept bytes it gives.
	task automatic predict_byte(input logic [7:0] c);
		kept_t item;
		step_kept.delete();
		case (lex_mode)
			MODE_STRING: begin
				step_kept.push_back(c);
				if (c == CH_DQUOTE || c == CH_NL)
					lex_mode = MODE_PLAIN;
				else if (c == CH_BSLASH)
					lex_mode = MODE_STR_ESC;
			end
			MODE_STR_ESC: begin
				// escaped byte passes untouched, even a quote or newline
				step_kept.push_back(c);
				lex_mode = MODE_STRING;
			end
			MODE_CHAR: begin
				// no escapes inside character literals
				step_kept.push_back(c);
				if (c == CH_SQUOTE || c == CH_NL)
					lex_mode = MODE_PLAIN;
			end
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					lex_mode = MODE_LINE;
					comments_seen++;
				end else if (c == CH_STAR) begin
					lex_mode  = MODE_BLOCK;
					star_seen = 1'b0;
					comments_seen++;
				end else begin
					// release the held slash, then treat this byte as plain text
					step_kept.push_back(CH_SLASH);
					lex_mode = MODE_PLAIN;
					plain_char(c);
				end
			end
			MODE_LINE: begin
				if (c == CH_BSLASH) begin
					lex_mode = MODE_LINE_ESC;
				end else if (c == CH_NL) begin
					step_kept.push_back(c);
					lex_mode = MODE_PLAIN;
				end
			end
			MODE_LINE_ESC: begin
				// hidden byte, a newline does not end the comment
				lex_mode = MODE_LINE;
			end
			MODE_BLOCK: begin
				if (star_seen && c == CH_SLASH)
					lex_mode = MODE_PLAIN;
				else
					star_seen = (c == CH_STAR);
			end
			default: plain_char(c);
		endcase
		foreach (step_kept[i]) begin
			item.kept = step_kept[i];
			item.last = (i == step_kept.size() - 1);
			kept_exp_q.push_back(item);
		end
		if (step_kept.size() == 2)
			double_results++;
	endtask

	// Compare one kept byte from the port against the oldest prediction.
	task automatic check_kept(input logic [7:0] got_byte, input logic got_last);
		kept_t want;
		results_seen++;
		if (kept_exp_q.size() == 0) begin
			$display("%0t: unexpected kept byte, expected none, actual %02h last %0b",
				$time, got_byte, got_last);
			err_count++;
		end else begin
			want = kept_exp_q.pop_front();
			if (got_byte !== want.kept) begin
				$display("%0t: kept_byte mismatch, expected %02h, actual %02h",
					$time, want.kept, got_byte);
				err_count++;
			end
			if (got_last !== want.last) begin
				$display("%0t: run_last mismatch on byte %02h, expected %0b, actual %0b",
					$time, want.kept, want.last, got_last);
				err_count++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			source_q.push_back(s[i]);
	endtask

	// Mostly printable text, with full-range bytes mixed in so every bit toggles.
	function automatic logic [7:0] body_byte();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly short idles, a few long ones, none during a quiet stretch.
	function automatic int pick_gap(input logic quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One C-like token with random content: code, literal, comment, lone slash or noise.
	task automatic add_fragment();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = $urandom_range(0, 8);
		if (r < 30) begin
			repeat (n + 1)
				source_q.push_back(($urandom_range(0, 7) == 0) ? CH_NL : body_byte());
		end else if (r < 45) begin
			source_q.push_back(CH_DQUOTE);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					source_q.push_back(CH_BSLASH);
					source_q.push_back(($urandom_range(0, 1) == 0) ? CH_DQUOTE : body_byte());
				end else begin
					source_q.push_back(body_byte());
				end
			end
			source_q.push_back(($urandom_range(0, 4) == 0) ? CH_NL : CH_DQUOTE);
		end else if (r < 55) begin
			source_q.push_back(CH_SQUOTE);
			repeat ($urandom_range(1, 2))
				source_q.push_back(($urandom_range(0, 4) == 0) ? CH_BSLASH : body_byte());
			source_q.push_back(($urandom_range(0, 4) == 0) ? CH_NL : CH_SQUOTE);
		end else if (r < 70) begin
			source_q.push_back(CH_SLASH);
			source_q.push_back(CH_SLASH);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) begin
					source_q.push_back(CH_BSLASH);
					source_q.push_back(($urandom_range(0, 1) == 0) ? CH_NL : body_byte());
				end else begin
					source_q.push_back(body_byte());
				end
			end
			source_q.push_back(CH_NL);
		end else if (r < 85) begin
			source_q.push_back(CH_SLASH);
			source_q.push_back(CH_STAR);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: source_q.push_back(CH_STAR);
					1: source_q.push_back(CH_SLASH);
					default: source_q.push_back(body_byte());
				endcase
			end
			source_q.push_back(CH_STAR);
			source_q.push_back(CH_SLASH);
		end else if (r < 92) begin
			source_q.push_back(CH_SLASH);
			source_q.push_back(body_byte());
		end else begin
			repeat ($urandom_range(1, 4))
				source_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Source driver: present bytes from source_q, predict each transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_byte  <= 8'h00;
			src_gap = 0;
		end else begin
			src_hold = text_valid && !text_ready;
			if (text_valid && text_ready) begin
				predict_byte(text_byte);
				bytes_sent++;
			end
			// Hold the byte until it transfers; otherwise idle out the gap or advance.
			if (!src_hold) begin
				if (src_gap > 0) begin
					src_gap--;
					text_valid <= 1'b0;
				end else if (source_q.size() > 0) begin
					text_byte  <= source_q.pop_front();
					text_valid <= 1'b1;
					src_gap = pick_gap(quiet_in);
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sink monitor: check each transfer, stall ready at random
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_ready <= 1'b0;
			snk_stall = 0;
		end else begin
			if (kept_valid && kept_ready)
				check_kept(kept_byte, run_last);
			if (snk_stall > 0) begin
				snk_stall--;
				kept_ready <= 1'b0;
			end else begin
				kept_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					snk_stall = pick_gap(quiet_out);
			end
		end
	end

	// Cycle count, plus the quiet-stretch draws for both sides
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 256 == 0) begin
			quiet_in  <= ($urandom_range(0, 3) == 0);
			quiet_out <= ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		// Directed opening:
		//   slash then char literal releases the slash, a backslash does not escape, newline ends the literal
		add_text("a/'\\\n");
		//   line comment with an escaped newline, closing newline kept
		add_text("//x\\\nq\n");
		//   the opening star does not close, a later star-slash does
		add_text("/*/**/");
		//   string with an escaped quote, closed by a quote
		add_text("\"\\\"\"");
		//   all-ones and all-zeros bytes are ordinary data
		source_q.push_back(8'hFF);
		source_q.push_back(8'h00);
		//   string closed by a newline
		add_text("\"\n");
		// Random part: mostly well-formed tokens with random content, some noise
		while (source_q.size() < RANDOM_BYTES + 25)
			add_fragment();
		// A trailing slash is held and never released
		source_q.push_back(CH_SLASH);

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for every byte to transfer and every prediction to be matched.
		@(negedge clk);
		while ((source_q.size() > 0 || text_valid || kept_exp_q.size() > 0)
				&& cycles < CYCLE_LIMIT)
			@(negedge clk);
		timed_out = (cycles >= CYCLE_LIMIT);

		if (timed_out) begin
			$display("%0t: timeout after %0d cycles, %0d results still expected",
				$time, cycles, kept_exp_q.size());
			$display("DONE: errors detected");
		end else begin
			// Let any stray result surface before the final verdict.
			repeat (TAIL_CYCLES) @(negedge clk);
			foreach (kept_exp_q[i]) begin
				$display("%0t: missing kept byte, expected %02h last %0b, actual none",
					$time, kept_exp_q[i].kept, kept_exp_q[i].last);
				err_count++;
			end
			$display("Sent %0d source bytes (%0d comments opened), checked %0d kept bytes,",
				bytes_sent, comments_seen, results_seen);
			$display("  %0d bytes released a held slash as a second result, %0d cycles.",
				double_results, cycles);
			if (err_count == 0)
				$display("DONE: 0 errors");
			else
				$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
